// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the reverb core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define DMR_ASSERT(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define DMR_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

// ----- hdl/dmr_pkg.sv -----
// Shared constants, types and register codes of the multi-tap reverb core.
package dmr_pkg;

	// Sizing of the history memory and the tap loop
	localparam int MAX_TAPS      = 256;
	localparam int HISTORY_DEPTH = 131072;
	localparam int HIST_AW       = $clog2(HISTORY_DEPTH);
	localparam int FILL_W        = $clog2(HISTORY_DEPTH + 1);
	localparam int KW            = $clog2(MAX_TAPS + 1);
	localparam int DLY_W         = $clog2(MAX_TAPS * 1024);
	localparam int IDX_W         = ((DLY_W > HIST_AW) ? DLY_W : HIST_AW) + 1;

	// Jitter table
	localparam int JIT_DEPTH = 256;
	localparam int JIT_AW    = 8;
	localparam int JIT_W     = 9;

	// Field and register widths
	localparam int SAMP_W    = 16;
	localparam int SPACING_W = 10;
	localparam int COEF_W    = 15;
	localparam int AMP_W     = 16;
	localparam logic [AMP_W-1:0] AMP_ONE = 16'h8000;

	// Accumulator and shared multiplier widths
	localparam int ACC_W  = $clog2(MAX_TAPS) + 32;
	localparam int LO_W   = ACC_W / 2;
	localparam int HI_W   = ACC_W - LO_W;
	localparam int SUM_W  = ACC_W + 16;
	localparam int MA_W   = (HI_W > LO_W) ? HI_W : LO_W + 1;
	localparam int MB_W   = AMP_W + 1;
	localparam int P_W    = MA_W + MB_W;
	localparam int Q_FRAC = 30;
	localparam int Q_W    = SUM_W - Q_FRAC;

	// Register indexes of the configuration port
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TAP_SPACING  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DECAY_FACTOR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CUTOFF_LEVEL = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_GAIN  = 2'd3;

	// Register reset values
	localparam logic [SPACING_W-1:0] RST_TAP_SPACING  = 10'd480;
	localparam logic [COEF_W-1:0]    RST_DECAY_FACTOR = 15'd32440;
	localparam logic [COEF_W-1:0]    RST_CUTOFF_LEVEL = 15'd3277;
	localparam logic [COEF_W-1:0]    RST_OUTPUT_GAIN  = 15'd3277;

	// Input item kinds
	localparam logic FUNC_SAMPLE = 1'b0;
	localparam logic FUNC_LOAD   = 1'b1;

	typedef struct packed {
		logic [SPACING_W-1:0] tap_spacing;
		logic [COEF_W-1:0]    decay_factor;
		logic [COEF_W-1:0]    cutoff_level;
		logic [COEF_W-1:0]    output_gain;
	} cfg_t;

	typedef struct packed {
		logic              en;
		logic [JIT_AW-1:0] slot;
		logic [JIT_W-1:0]  value;
	} jit_wr_t;

	typedef struct packed {
		logic             vld;
		logic             live;
		logic [AMP_W-1:0] amp;
	} tap_t;

	typedef enum logic {
		MAC_ACC,
		MAC_LOAD_SHL
	} mac_kind_t;

	typedef struct packed {
		logic                   en;
		mac_kind_t              kind;
		logic signed [MA_W-1:0] a;
		logic signed [MB_W-1:0] b;
	} mac_op_t;

endpackage

// ----- hdl/dmr_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module dmr_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// Write on request, register the read word every cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- hdl/dmr_tap_gen.sv -----
// Tap sequencer: amplitude decay, jitter lookup and history address generation.
`include "assert_macros.svh"
module dmr_tap_gen
	import dmr_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  cfg_t               cfg,
	input  logic [FILL_W-1:0]  fill,
	input  logic [HIST_AW-1:0] wp,
	input  jit_wr_t            jit_wr,
	output logic [HIST_AW-1:0] hist_addr,
	output tap_t               tap,
	output logic               busy
);

	// Loop state
	logic                 run_q;
	logic [KW-1:0]        k_q;
	logic [AMP_W-1:0]     amp_q;
	logic [DLY_W-1:0]     base_q;
	logic [SPACING_W-1:0] jmax_q;
	logic [JIT_DEPTH-1:0] jv_q;

	// Pipeline stages
	logic                 vld_s1, vld_s2, vld_s3;
	logic                 jv_s1, live_s3;
	logic [AMP_W-1:0]     amp_s1, amp_s2, amp_s3;
	logic [DLY_W-1:0]     base_s1, delay_s2;

	logic                 issue;
	logic [JIT_AW-1:0]    jit_rd_addr;
	logic [JIT_W-1:0]     jit_rd_data;
	logic [JIT_W-1:0]     jit_raw;
	logic [SPACING_W-1:0] jit_clamp;
	logic [AMP_W+COEF_W-1:0] amp_prod;
	logic [IDX_W-1:0]     diff, diff_wrap;
	logic                 hit;

	dmr_ram #(
		.WIDTH(JIT_W),
		.DEPTH(JIT_DEPTH)
	) u_jit_ram (
		.clk    (clk),
		.wr_en  (jit_wr.en),
		.wr_addr(jit_wr.slot),
		.wr_data(jit_wr.value),
		.rd_addr(jit_rd_addr),
		.rd_data(jit_rd_data)
	);

	// Issue a tap while the amplitude stays above the cutoff
	assign issue       = run_q && (k_q < KW'(MAX_TAPS)) && (amp_q > AMP_W'(cfg.cutoff_level));
	assign jit_rd_addr = JIT_AW'(k_q);
	assign amp_prod    = amp_q * cfg.decay_factor;

	// Advance the tap loop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			k_q   <= '0;
		end else if (start) begin
			run_q <= 1'b1;
			k_q   <= '0;
		end else if (issue) begin
			k_q <= k_q + 1'b1;
		end else begin
			run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			amp_q  <= AMP_ONE;
			base_q <= '0;
			jmax_q <= (cfg.tap_spacing == '0) ? '0 : cfg.tap_spacing - 1'b1;
		end else if (issue) begin
			amp_q  <= amp_prod[AMP_W+COEF_W-1:COEF_W];
			base_q <= base_q + DLY_W'(cfg.tap_spacing);
		end
	end

	// Mark jitter entries as written
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q <= '0;
		end else if (jit_wr.en) begin
			jv_q[jit_wr.slot] <= 1'b1;
		end
	end

	// Stage 1: clamp the jitter and form the delay
	assign jit_raw   = jv_s1 ? jit_rd_data : '0;
	assign jit_clamp = (SPACING_W'(jit_raw) > jmax_q) ? jmax_q : SPACING_W'(jit_raw);

	// Stage 2: check the delay against the fill and wrap the read address
	assign hit       = IDX_W'(delay_s2) < IDX_W'(fill);
	assign diff      = IDX_W'(wp) - IDX_W'(delay_s2);
	assign diff_wrap = diff + IDX_W'(HISTORY_DEPTH);
	assign hist_addr = diff[IDX_W-1] ? diff_wrap[HIST_AW-1:0] : diff[HIST_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			vld_s2  <= 1'b0;
			vld_s3  <= 1'b0;
			live_s3 <= 1'b0;
		end else begin
			vld_s1  <= issue;
			vld_s2  <= vld_s1;
			vld_s3  <= vld_s2;
			live_s3 <= vld_s2 && hit;
		end
	end

	always_ff @(posedge clk) begin
		jv_s1    <= jv_q[jit_rd_addr];
		amp_s1   <= amp_q;
		base_s1  <= base_q;
		amp_s2   <= amp_s1;
		delay_s2 <= base_s1 + DLY_W'(jit_clamp);
		amp_s3   <= amp_s2;
	end

	assign tap  = '{vld: vld_s3, live: live_s3, amp: amp_s3};
	assign busy = run_q || vld_s1 || vld_s2 || vld_s3;

	`DMR_ASSERT_IMP(a_amp_falls, issue && $past(issue), amp_q <= $past(amp_q), "tap amplitude rose between taps")

endmodule

// ----- hdl/dmr_mac.sv -----
// Shared multiply-accumulate unit for tap sums and output scaling.
module dmr_mac
	import dmr_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  mac_op_t                 op,
	output logic signed [SUM_W-1:0] acc,
	output logic                    busy
);

	logic signed [MA_W-1:0]  a_in;
	logic signed [MB_W-1:0]  b_in;
	logic signed [P_W-1:0]   prod_s1;
	logic                    en_s1;
	mac_kind_t               kind_s1;
	logic signed [SUM_W-1:0] acc_q;

	assign a_in = op.a;
	assign b_in = op.b;

	// Hold the request valid and kind alongside the product
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1   <= 1'b0;
			kind_s1 <= MAC_ACC;
		end else begin
			en_s1   <= op.en;
			kind_s1 <= op.kind;
		end
	end

	// Multiply, then accumulate or load shifted
	always_ff @(posedge clk) begin
		prod_s1 <= a_in * b_in;
		if (en_s1) begin
			case (kind_s1)
				MAC_LOAD_SHL: acc_q <= SUM_W'(prod_s1) <<< LO_W;
				default:      acc_q <= acc_q + SUM_W'(prod_s1);
			endcase
		end
	end

	assign acc  = acc_q;
	assign busy = en_s1;

endmodule

// ----- hdl/decaying_multitap_reverb_core.sv -----
// Top level of the multi-tap reverb core: stream ports, registers and sequencer.
//
// Each audio sample is stored in a 128K-entry history memory and answered by one
// output sample: the sum of up to 256 decaying taps, scaled by the output gain,
// truncated toward zero and saturated to 16 bits (clipped flags saturation).
// An audio item runs N taps (the amplitude starts at 1.0 and is multiplied by
// the decay factor per tap until it falls to the cutoff level or 256 taps are
// done; about 230 with reset values): the single multiply-accumulate unit takes
// one tap per cycle, followed by the pipeline drain and the two-part gain
// multiply. A jitter load item yields no output. The input is not ready while an
// audio item is in work; a finished result waits in the output register while
// the next item is taken. History needs no clearing after reset: entries not yet
// written since reset read as zero through a fill count.
`include "assert_macros.svh"
module decaying_multitap_reverb_core
	import dmr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// Input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [39:0]          s_tdata,   // sample_in[15:0], tap_slot[23:16], jitter_value[32:24]
	input  logic                 s_tuser,   // func[0]
	// Output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [15:0]          m_tdata,   // sample_out[15:0]
	output logic                 m_tuser,   // clipped[0]
	// Configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RUN,
		ST_SCL_HI,
		ST_SCL_LO,
		ST_SCL_ADD,
		ST_FIN
	} state_t;

	state_t             state_q;
	cfg_t               cfg_q;
	logic [HIST_AW-1:0] wp_q;
	logic [FILL_W-1:0]  fill_q;
	logic               out_vld_q;
	logic [SAMP_W-1:0]  out_data_q;
	logic               out_clip_q;

	logic                     s_acc;
	logic                     take_sample;
	jit_wr_t                  jit_wr;
	logic [HIST_AW-1:0]       hist_rd_addr;
	logic [SAMP_W-1:0]        hist_rd_data;
	logic signed [SAMP_W-1:0] hist_sample;
	tap_t                     tap;
	logic                     gen_busy;
	mac_op_t                  mac_op;
	logic signed [SUM_W-1:0]  acc;
	logic                     mac_busy;
	logic signed [HI_W-1:0]   acc_hi;
	logic signed [Q_W-1:0]    q_floor, q_res;
	logic                     q_corr, sat_hi, sat_lo;
	logic                     out_free;

	// Input request handshake
	assign s_tready    = (state_q == ST_IDLE);
	assign s_acc       = s_tvalid && s_tready;
	assign take_sample = s_acc && (s_tuser == FUNC_SAMPLE);
	assign jit_wr      = '{en: s_acc && (s_tuser == FUNC_LOAD), slot: s_tdata[23:16],
		value: s_tdata[32:24]};

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tap_spacing  <= RST_TAP_SPACING;
			cfg_q.decay_factor <= RST_DECAY_FACTOR;
			cfg_q.cutoff_level <= RST_CUTOFF_LEVEL;
			cfg_q.output_gain  <= RST_OUTPUT_GAIN;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_TAP_SPACING:  cfg_q.tap_spacing  <= cfg_data[SPACING_W-1:0];
				CFG_DECAY_FACTOR: cfg_q.decay_factor <= cfg_data;
				CFG_CUTOFF_LEVEL: cfg_q.cutoff_level <= cfg_data;
				CFG_OUTPUT_GAIN:  cfg_q.output_gain  <= cfg_data;
				default: ;
			endcase
		end
	end

	dmr_ram #(
		.WIDTH(SAMP_W),
		.DEPTH(HISTORY_DEPTH)
	) u_hist_ram (
		.clk    (clk),
		.wr_en  (take_sample),
		.wr_addr(wp_q),
		.wr_data(s_tdata[15:0]),
		.rd_addr(hist_rd_addr),
		.rd_data(hist_rd_data)
	);

	dmr_tap_gen u_tap_gen (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (take_sample),
		.cfg      (cfg_q),
		.fill     (fill_q),
		.wp       (wp_q),
		.jit_wr   (jit_wr),
		.hist_addr(hist_rd_addr),
		.tap      (tap),
		.busy     (gen_busy)
	);

	dmr_mac u_mac (
		.clk   (clk),
		.arst_n(arst_n),
		.op    (mac_op),
		.acc   (acc),
		.busy  (mac_busy)
	);

	assign hist_sample = hist_rd_data;
	assign acc_hi      = acc[ACC_W-1:LO_W];

	// Drive the shared multiplier: clear, taps, then gain in two halves
	always_comb begin
		mac_op = '{en: 1'b0, kind: MAC_ACC, a: '0, b: '0};
		unique case (state_q)
			ST_IDLE: begin
				mac_op.en   = take_sample;
				mac_op.kind = MAC_LOAD_SHL;
			end
			ST_RUN: begin
				mac_op.en = tap.vld;
				mac_op.a  = tap.live ? MA_W'(hist_sample) : '0;
				mac_op.b  = MB_W'(tap.amp);
			end
			ST_SCL_HI: begin
				mac_op.en   = 1'b1;
				mac_op.kind = MAC_LOAD_SHL;
				mac_op.a    = MA_W'(acc_hi);
				mac_op.b    = MB_W'(cfg_q.output_gain);
			end
			ST_SCL_LO: begin
				mac_op.en = 1'b1;
				mac_op.a  = MA_W'(acc[LO_W-1:0]);
				mac_op.b  = MB_W'(cfg_q.output_gain);
			end
			default: ;
		endcase
	end

	// Truncate toward zero and saturate
	assign q_floor  = acc[SUM_W-1:Q_FRAC];
	assign q_corr   = acc[SUM_W-1] && (acc[Q_FRAC-1:0] != '0);
	assign q_res    = q_floor + (q_corr ? Q_W'(1) : Q_W'(0));
	assign sat_hi   = q_res > Q_W'(32767);
	assign sat_lo   = q_res < -Q_W'(32768);
	assign out_free = !out_vld_q || m_tready;

	// Sequencer, write pointer, fill count and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			wp_q       <= '0;
			fill_q     <= '0;
			out_vld_q  <= 1'b0;
			out_data_q <= '0;
			out_clip_q <= 1'b0;
		end else begin
			// Drop a taken result unless the finish step replaces it
			if (out_vld_q && m_tready && (state_q != ST_FIN)) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (take_sample) begin
						state_q <= ST_RUN;
						if (fill_q != FILL_W'(HISTORY_DEPTH)) begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_RUN: begin
					if (!gen_busy && !mac_busy) begin
						state_q <= ST_SCL_HI;
					end
				end
				ST_SCL_HI:  state_q <= ST_SCL_LO;
				ST_SCL_LO:  state_q <= ST_SCL_ADD;
				ST_SCL_ADD: state_q <= ST_FIN;
				ST_FIN: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_clip_q <= sat_hi || sat_lo;
						out_data_q <= sat_hi ? 16'h7fff : (sat_lo ? 16'h8000 : q_res[SAMP_W-1:0]);
						wp_q       <= (wp_q == HIST_AW'(HISTORY_DEPTH - 1)) ? '0 : wp_q + 1'b1;
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;
	assign m_tuser  = out_clip_q;

	`DMR_ASSERT_IMP(a_ready_idle, s_tready, !gen_busy && !mac_busy, "input ready while datapath busy")
	`DMR_ASSERT_IMP(a_out_from_fin, $rose(m_tvalid), $past(state_q) == ST_FIN, "result raised outside finish")
	`DMR_ASSERT(a_fill_bound, fill_q <= FILL_W'(HISTORY_DEPTH), "fill count beyond history depth")

endmodule

// ----- bench/decaying_multitap_reverb_core_test.sv -----
// Self-checking stream testbench for the multi-tap reverb core.
`timescale 1ns / 100ps
module decaying_multitap_reverb_core_test;
	import dmr_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 16;
	localparam int TAIL_CYCLES    = 300;
	localparam int RANDOM_PHASES  = 8;
	localparam int PHASE_ITEMS    = 140;

	typedef struct packed {
		logic signed [SAMP_W-1:0] sample_out;
		logic                     clipped;
	} reverb_out_t;

	// Tracks history, jitter table and registers; predicts each output sample
	class reverb_tracker;
		bit signed [SAMP_W-1:0] history [HISTORY_DEPTH];
		bit [HIST_AW-1:0]       write_ptr;
		bit [JIT_W-1:0]         jitter_table [JIT_DEPTH];
		cfg_t                   regs;
		reverb_out_t            awaited [$];
		int                     mismatches;

		function new();
			regs.tap_spacing  = RST_TAP_SPACING;
			regs.decay_factor = RST_DECAY_FACTOR;
			regs.cutoff_level = RST_CUTOFF_LEVEL;
			regs.output_gain  = RST_OUTPUT_GAIN;
			write_ptr = '0;
			mismatches = 0;
		endfunction

		// Mask the written value to the width of the addressed register
		function void set_register(logic [CFG_IDX_W-1:0] idx, logic [COEF_W-1:0] value);
			case (idx)
				CFG_TAP_SPACING:  regs.tap_spacing  = value[SPACING_W-1:0];
				CFG_DECAY_FACTOR: regs.decay_factor = value;
				CFG_CUTOFF_LEVEL: regs.cutoff_level = value;
				CFG_OUTPUT_GAIN:  regs.output_gain  = value;
				default: ;
			endcase
		endfunction

		// Apply one accepted request; audio requests queue the expected output
		function void note_request(logic func, logic [SAMP_W-1:0] sample,
			logic [JIT_AW-1:0] slot, logic [JIT_W-1:0] jit_value);
			int unsigned      amp;
			int unsigned      jmax;
			int unsigned      jit;
			int unsigned      dly;
			int unsigned      k;
			bit [HIST_AW-1:0] tap_addr;
			longint           acc;
			longint           scaled;
			reverb_out_t      res;
			if (func == FUNC_LOAD) begin
				jitter_table[slot] = jit_value;
				return;
			end
			// Store first, so a zero delay reads the current sample
			history[write_ptr] = sample;
			jmax = (regs.tap_spacing == 0) ? 0 : 32'(regs.tap_spacing) - 1;
			amp = 32'(AMP_ONE);
			acc = 0;
			for (k = 0; k < MAX_TAPS && amp > 32'(regs.cutoff_level); k++) begin
				jit = 32'(jitter_table[k % JIT_DEPTH]);
				if (jit > jmax)
					jit = jmax;
				dly = k * 32'(regs.tap_spacing) + jit;
				// Taps reaching past the memory contribute nothing
				if (dly < HISTORY_DEPTH) begin
					tap_addr = HIST_AW'(32'(write_ptr) - dly);
					acc += longint'(history[tap_addr]) * longint'(amp);
				end
				amp = (amp * 32'(regs.decay_factor)) >> 15;
			end
			write_ptr++;
			// Scale by the gain, truncate toward zero, saturate
			scaled = (acc * longint'(regs.output_gain)) / (64'sd1 <<< Q_FRAC);
			if (scaled > 32767) begin
				res.sample_out = 16'sh7FFF;
				res.clipped = 1'b1;
			end else if (scaled < -32768) begin
				res.sample_out = 16'sh8000;
				res.clipped = 1'b1;
			end else begin
				res.sample_out = scaled[SAMP_W-1:0];
				res.clipped = 1'b0;
			end
			awaited.push_back(res);
		endfunction

		// Compare an accepted output with the oldest expectation
		function void check_output(logic [SAMP_W-1:0] got_sample, logic got_clip);
			reverb_out_t want;
			if (awaited.size() == 0) begin
				$error("unexpected output: sample_out %0d, clipped %0b",
					$signed(got_sample), got_clip);
				mismatches++;
				return;
			end
			want = awaited.pop_front();
			if (got_sample !== want.sample_out) begin
				$error("sample_out: expected %0d, got %0d", want.sample_out, $signed(got_sample));
				mismatches++;
			end
			if (got_clip !== want.clipped) begin
				$error("clipped: expected %0b, got %0b", want.clipped, got_clip);
				mismatches++;
			end
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [39:0]          s_tdata;   // sample_in[15:0], tap_slot[23:16], jitter_value[32:24]
	logic                 s_tuser;   // func[0]
	logic                 m_tvalid;
	logic                 m_tready;
	logic [15:0]          m_tdata;   // sample_out[15:0]
	logic                 m_tuser;   // clipped[0]
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [COEF_W-1:0]    cfg_data;

	reverb_tracker tracker;
	bit            quiet_sender;
	int            idle_cycles = 0;

	decaying_multitap_reverb_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Mostly no gap, often a short one, now and then a long one
	function automatic int idle_length();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Coefficient with a bias toward both extremes
	function automatic logic [COEF_W-1:0] pick_coef(int lo, int hi);
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return '0;
		if (r == 1)
			return 15'd32767;
		return COEF_W'($urandom_range(lo, hi));
	endfunction

	function automatic logic [SAMP_W-1:0] pick_sample();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 16'h7FFF;
		if (r == 1)
			return 16'h8000;
		if (r == 2)
			return SAMP_W'($urandom_range(0, 15) - 8);
		return SAMP_W'($urandom);
	endfunction

	// Present one request after a random gap and hold it until taken
	task automatic send_item(input logic func, input logic [SAMP_W-1:0] sample,
		input logic [JIT_AW-1:0] slot, input logic [JIT_W-1:0] jit_value);
		int gap;
		gap = quiet_sender ? 0 : idle_length();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= {7'd0, jit_value, slot, sample};
		do @(posedge clk); while (s_tready !== 1'b1);
		tracker.note_request(func, sample, slot, jit_value);
	endtask

	task automatic send_audio(input logic [SAMP_W-1:0] sample);
		send_item(FUNC_SAMPLE, sample, JIT_AW'($urandom), JIT_W'($urandom));
	endtask

	task automatic send_load(input logic [JIT_AW-1:0] slot, input logic [JIT_W-1:0] jit_value);
		send_item(FUNC_LOAD, SAMP_W'($urandom), slot, jit_value);
	endtask

	// Drop the request line and wait for every expected output
	task automatic drain(input int tail);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.awaited.size() != 0);
		repeat (tail) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		tracker.set_register(idx, value);
	endtask

	// Rewrite all four registers once the core is idle
	task automatic reconfigure(input logic [COEF_W-1:0] spacing_word,
		input logic [COEF_W-1:0] decay, input logic [COEF_W-1:0] cutoff,
		input logic [COEF_W-1:0] gain);
		drain(SETTLE_CYCLES);
		write_reg(CFG_TAP_SPACING, spacing_word);
		write_reg(CFG_DECAY_FACTOR, decay);
		write_reg(CFG_CUTOFF_LEVEL, cutoff);
		write_reg(CFG_OUTPUT_GAIN, gain);
		cfg_we <= 1'b0;
	endtask

	// Check every accepted output
	always @(posedge clk) begin
		if (arst_n && m_tvalid === 1'b1 && m_tready)
			tracker.check_output(m_tdata, m_tuser);
	end

	// Abort when nothing moves on either stream for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			$display("decaying_multitap_reverb_core test failed");
			$finish;
		end
	end

	// Output back-pressure: random stalls with occasional stall-free stretches
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		@(posedge clk);
		forever begin
			if ($urandom_range(0, 11) == 0) begin
				m_tready <= 1'b1;
				repeat ($urandom_range(100, 400)) @(posedge clk);
			end else begin
				stall = idle_length();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
		end
	end

	initial begin
		int                     ph;
		int                     n;
		int                     r;
		logic [SPACING_W-1:0]   spacing;
		logic [COEF_W-1:0]      spacing_word;

		tracker = new();
		quiet_sender = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = FUNC_SAMPLE;
		cfg_we = 1'b0;
		cfg_index = CFG_TAP_SPACING;
		cfg_data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset registers: early samples read a cleared history, tap 0 is the new sample
		send_audio(16'h7FFF);
		send_audio(16'h8000);
		send_audio(16'h0000);
		send_audio(16'h0001);
		send_audio(16'hFFFF);

		// Unit spacing, full taps, full gain: drive into both saturation limits
		reconfigure(15'd1, 15'd32767, 15'd0, 15'd32767);
		repeat (3) send_audio(16'h7FFF);
		repeat (4) send_audio(16'h8000);

		// Spacing masked to zero, single tap: jitter clamps to zero
		reconfigure(15'h7C00, 15'd0, 15'd0, 15'd32767);
		send_load(8'd0, 9'd511);
		send_audio(16'h1234);
		send_audio(16'h8000);

		// Small spacing with jitter beyond the slot, clamped at use
		reconfigure(15'd4, 15'd30000, 15'd1000, 15'd16384);
		send_load(8'd1, 9'd511);
		send_load(8'd2, 9'd2);
		send_load(8'd255, 9'd7);
		repeat (3) send_audio(pick_sample());

		// Widest spacing: late taps reach beyond the history memory
		reconfigure(15'd1023, 15'd32767, 15'd0, 15'd0);
		send_audio(16'h7FFF);
		send_audio(16'h8000);

		// Random phases, each under its own register setting
		for (ph = 0; ph < RANDOM_PHASES; ph++) begin
			quiet_sender = (ph % 3 == 1);
			r = $urandom_range(0, 9);
			if (r == 0)
				spacing = 10'd0;
			else if (r <= 5)
				spacing = SPACING_W'($urandom_range(1, 8));
			else if (r == 6)
				spacing = 10'd1023;
			else if (r == 7)
				spacing = SPACING_W'($urandom_range(9, 64));
			else
				spacing = SPACING_W'($urandom_range(1, 1023));
			spacing_word = {5'($urandom), spacing};
			if (ph == 0)
				reconfigure({5'h1F, 10'd2}, 15'd32767, 15'd0, 15'd32767);
			else if (ph == 1)
				reconfigure(COEF_W'(RST_TAP_SPACING), RST_DECAY_FACTOR, RST_CUTOFF_LEVEL,
					RST_OUTPUT_GAIN);
			else
				reconfigure(spacing_word, pick_coef(20000, 32767), pick_coef(0, 8000),
					pick_coef(0, 32767));
			for (n = 0; n < PHASE_ITEMS; n++) begin
				// Hold the sender once until the core has answered everything
				if (ph == 2 && n == PHASE_ITEMS / 2)
					drain(0);
				if ($urandom_range(0, 99) < 85)
					send_audio(pick_sample());
				else if ($urandom_range(0, 9) < 7)
					send_load(JIT_AW'($urandom_range(0, 15)), JIT_W'($urandom_range(0, 511)));
				else
					send_load(JIT_AW'($urandom_range(0, 255)), JIT_W'($urandom_range(0, 511)));
			end
		end

		drain(TAIL_CYCLES);
		if (tracker.mismatches == 0)
			$display("decaying_multitap_reverb_core test passed");
		else
			$display("decaying_multitap_reverb_core test failed");
		$finish;
	end

endmodule
